### rtl/jet_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Julia escape-time pixel block.
// No dependencies.
package jet_pkg;

  localparam int FRAC_BITS = 26;
  localparam int Z_W       = 32;
  localparam int PIX_W     = 10;
  localparam int STEP_W    = 27;
  localparam int CNT_W     = 10;
  localparam int PROD_W    = 2 * Z_W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;
  localparam int WIDE_W    = SQ_W + 2;
  localparam int SEQ_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [Z_W-1:0] PI_Q = Z_W'(64'd3373259426 >> (30 - FRAC_BITS));
  localparam logic signed [SQ_W:0]  FOUR_Q = (SQ_W+1)'(64'd4 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE  = 3'd0,
    REG_ORIGIN_IM  = 3'd1,
    REG_PIXEL_STEP = 3'd2,
    REG_CONST_RE   = 3'd3,
    REG_CONST_IM   = 3'd4,
    REG_MAX_ITER   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic             reached_max;
  } out_t;

  typedef struct packed {
    logic signed [Z_W-1:0] const_re;
    logic signed [Z_W-1:0] const_im;
    logic [CNT_W-1:0]      max_iter;
  } core_cfg_t;

  // start point handed to the iteration ring
  typedef struct packed {
    logic                  valid;
    logic signed [Z_W-1:0] zr;
    logic signed [Z_W-1:0] zi;
  } start_t;

  // finished pixel leaving the ring
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } done_t;

  // saturate a wide signed value to the coordinate width
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[WIDE_W-1:Z_W-1];
    hi_zeros = ~|v[WIDE_W-1:Z_W-1];
    if (hi_ones || hi_zeros) return v[Z_W-1:0];
    else if (v[WIDE_W-1])    return {1'b1, {(Z_W-1){1'b0}}};
    else                     return {1'b0, {(Z_W-1){1'b1}}};
  endfunction

endpackage

### rtl/julia_escape_time_pixel_top.sv
`timescale 1ns / 1ps
// Top level of the Julia escape-time pixel block: config registers, start-point
// pipeline, output register. Depends on jet_pkg and jet_core.
//
// Each item (col, row) becomes z = origin + pixel*pixel_step in a three-stage
// start pipeline, then enters a four-stage iteration ring where one pass of the
// ring is one iteration. Up to four items share the ring, interleaved. Results
// come out in input order: a finished item keeps circulating until it is the
// oldest. Arithmetic is signed Q6.26, saturating; configuration must be written
// only when idle, which the block itself does not enforce.
module julia_escape_time_pixel_top import jet_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [Z_W-1:0]       cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data
);

  logic signed [Z_W-1:0] origin_re, origin_im, const_re, const_im;
  logic [STEP_W-1:0]     pixel_step;
  logic [CNT_W-1:0]      max_iter;

  // start pipeline registers
  logic                      e0_v, e1_v;
  in_t                       e0;
  logic [PIX_W+STEP_W-1:0]   col_off, row_off;
  start_t                    pend;
  logic                      e0_adv, e1_adv, pend_adv;

  core_cfg_t cfg;
  logic      start_take;
  done_t     retire;
  logic      retire_ready;

  assign cfg = '{const_re: const_re, const_im: const_im, max_iter: max_iter};

  // each stage moves when the next one is empty or moving
  assign pend_adv = !pend.valid || start_take;
  assign e1_adv   = !e1_v || pend_adv;
  assign e0_adv   = !e0_v || e1_adv;
  assign in_stall = !e0_adv;
  assign retire_ready = !out_valid || !out_stall;

  jet_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (pend),
    .start_take   (start_take),
    .retire       (retire),
    .retire_ready (retire_ready)
  );

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_re  <= -32'sd107374182;
      origin_im  <= -32'sd87241523;
      pixel_step <= STEP_W'(335544);
      const_re   <= 32'sd19126026;
      const_im   <= 32'sd671089;
      max_iter   <= CNT_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ORIGIN_RE:  origin_re  <= cfg_wdata;
        REG_ORIGIN_IM:  origin_im  <= cfg_wdata;
        REG_PIXEL_STEP: pixel_step <= cfg_wdata[STEP_W-1:0];
        REG_CONST_RE:   const_re   <= cfg_wdata;
        REG_CONST_IM:   const_im   <= cfg_wdata;
        REG_MAX_ITER:   max_iter   <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // start pipeline: capture, scale by step, add origin and saturate
  always_ff @(posedge clk) begin
    if (e0_adv) e0 <= in_data;
    if (e1_adv) begin
      col_off <= e0.col * pixel_step;
      row_off <= e0.row * pixel_step;
    end
    if (pend_adv) begin
      pend.zr <= sat_z({{(WIDE_W-Z_W){origin_re[Z_W-1]}}, origin_re}
                       + WIDE_W'(col_off));
      pend.zi <= sat_z({{(WIDE_W-Z_W){origin_im[Z_W-1]}}, origin_im}
                       + WIDE_W'(row_off));
    end
    if (rst) begin
      e0_v       <= 1'b0;
      e1_v       <= 1'b0;
      pend.valid <= 1'b0;
    end else begin
      if (e0_adv)   e0_v       <= in_valid;
      if (e1_adv)   e1_v       <= e0_v;
      if (pend_adv) pend.valid <= e1_v;
    end
  end

  // output register: hold while stalled, load a retired item
  always_ff @(posedge clk) begin
    if (retire.valid) begin
      out_data.iter_count  <= retire.count;
      out_data.reached_max <= (retire.count == max_iter);
    end
    if (rst) out_valid <= 1'b0;
    else if (retire.valid) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

endmodule

### rtl/jet_core.sv
`timescale 1ns / 1ps
// Four-stage iteration ring: up to four pixels circulate and share one datapath.
// Depends on jet_pkg.
module jet_core import jet_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_cfg_t cfg,
  input  start_t    start,
  output logic      start_take,
  output done_t     retire,
  input  logic      retire_ready
);

  typedef struct packed {
    logic                  v;
    logic                  done;
    logic [SEQ_W-1:0]      seq;
    logic [CNT_W-1:0]      cnt;
    logic signed [Z_W-1:0] zr;
    logic signed [Z_W-1:0] zi;
  } slot_t;

  slot_t r0, r1, r2, r3;
  logic signed [PROD_W-1:0] p_rr, p_ii, p_pi;     // stage 0 products
  logic signed [SQ_W-1:0]   sr, si;               // stage 1 squares
  logic signed [Z_W-1:0]    pz;
  logic                     esc2;
  logic signed [PROD_W-1:0] p_pz;                 // stage 2 product
  logic signed [Z_W-1:0]    zr_new;
  logic [SEQ_W-1:0]         ins_seq, out_seq;

  logic  do_retire;
  slot_t s_in, s3_next;
  logic signed [SQ_W:0] sq_sum;
  logic signed [Z_W-1:0] zi_new;

  assign do_retire  = r3.v && r3.done && (r3.seq == out_seq) && retire_ready;
  assign start_take = start.valid && (!r3.v || do_retire);
  assign retire.valid = do_retire;
  assign retire.count = r3.cnt;

  always_comb begin
    s_in = r3;
    if (do_retire) s_in.v = 1'b0;
    if (start_take) begin
      s_in.v    = 1'b1;
      s_in.done = 1'b0;
      s_in.seq  = ins_seq;
      s_in.cnt  = '0;
      s_in.zr   = start.zr;
      s_in.zi   = start.zi;
    end
  end

  assign sq_sum = {sr[SQ_W-1], sr} + {si[SQ_W-1], si};

  // stage 3: close out or advance one iteration
  always_comb begin
    s3_next = r2;
    zi_new  = sat_z({{2{p_pz[PROD_W-1]}}, p_pz[PROD_W-1:FRAC_BITS]}
                    + {{(WIDE_W-Z_W){cfg.const_im[Z_W-1]}}, cfg.const_im});
    if (r2.v && !r2.done) begin
      if (r2.cnt >= cfg.max_iter || esc2) begin
        s3_next.done = 1'b1;
      end else begin
        s3_next.cnt = r2.cnt + 1'b1;
        s3_next.zr  = zr_new;
        s3_next.zi  = zi_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: squares and pi scaling
    p_rr <= s_in.zr * s_in.zr;
    p_ii <= s_in.zi * s_in.zi;
    p_pi <= PI_Q * s_in.zi;
    // stage 1: drop fraction bits, saturate the pi-scaled imaginary part
    sr   <= p_rr[PROD_W-1:FRAC_BITS];
    si   <= p_ii[PROD_W-1:FRAC_BITS];
    pz   <= sat_z({{2{p_pi[PROD_W-1]}}, p_pi[PROD_W-1:FRAC_BITS]});
    // stage 2: escape test, cross product and new real part
    esc2 <= (sq_sum >= FOUR_Q);
    p_pz <= pz * r1.zr;
    zr_new <= sat_z({{2{sr[SQ_W-1]}}, sr} - {{2{si[SQ_W-1]}}, si}
                    + {{(WIDE_W-Z_W){cfg.const_re[Z_W-1]}}, cfg.const_re});
    if (rst) begin
      r0.v <= 1'b0;
      r1.v <= 1'b0;
      r2.v <= 1'b0;
      r3.v <= 1'b0;
      ins_seq <= '0;
      out_seq <= '0;
    end else begin
      r0 <= s_in;
      r1 <= r0;
      r2 <= r1;
      r3 <= s3_next;
      if (start_take) ins_seq <= ins_seq + 1'b1;
      if (do_retire)  out_seq <= out_seq + 1'b1;
    end
  end

endmodule

### rtl/jet_checker.sv
`timescale 1ns / 1ps
// Port-level checks for julia_escape_time_pixel_top, attached by bind.
// Depends on jet_pkg.
module jet_checker import jet_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // reset empties the block and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // no result can get through start pipeline and ring this soon after reset
  a_min_latency: assert property (@(posedge clk)
    rst ##1 !rst ##1 !rst |-> !out_valid)
    else $error("result too soon after reset");

endmodule

bind julia_escape_time_pixel_top jet_checker u_jet_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
